// File: hw/rtl/assert_macros.svh
// Assertion helpers; define ASSERT_OFF to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, prop)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: hw/rtl/itp_pkg.sv
package itp_pkg;

  localparam int unsigned STACK_DEPTH = 32;
  localparam int unsigned QUEUE_DEPTH = 2;

  // operator codes held on the stack
  localparam logic [2:0] CODE_LPAREN = 3'd0;
  localparam logic [2:0] CODE_ADD    = 3'd1;
  localparam logic [2:0] CODE_SUB    = 3'd2;
  localparam logic [2:0] CODE_MUL    = 3'd3;
  localparam logic [2:0] CODE_DIV    = 3'd4;

  localparam logic [7:0] CHAR_LPAREN = 8'h28;
  localparam logic [7:0] CHAR_RPAREN = 8'h29;
  localparam logic [7:0] CHAR_MUL    = 8'h2A;
  localparam logic [7:0] CHAR_ADD    = 8'h2B;
  localparam logic [7:0] CHAR_SUB    = 8'h2D;
  localparam logic [7:0] CHAR_DIV    = 8'h2F;

  typedef enum logic [2:0] {
    CMD_OPERAND,
    CMD_LPAREN,
    CMD_RPAREN,
    CMD_OPER,
    CMD_END
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e  kind;
    logic [2:0] code;
    logic [7:0] sym;
  } cmd_t;

  function automatic logic [1:0] prec_of(logic [2:0] code);
    logic [1:0] p;
    unique case (code)
      CODE_MUL, CODE_DIV: p = 2'd2;
      CODE_ADD, CODE_SUB: p = 2'd1;
      default:            p = 2'd0;
    endcase
    return p;
  endfunction

  function automatic logic [7:0] code_char(logic [2:0] code);
    logic [7:0] ch;
    unique case (code)
      CODE_LPAREN: ch = CHAR_LPAREN;
      CODE_ADD:    ch = CHAR_ADD;
      CODE_SUB:    ch = CHAR_SUB;
      CODE_MUL:    ch = CHAR_MUL;
      CODE_DIV:    ch = CHAR_DIV;
      default:     ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

// File: hw/rtl/infix_to_postfix_converter_unit.sv
// Infix to postfix converter (shunting yard), one character per transaction.
// Input channel: in_valid_i/in_ready_o with symbol_i and end_of_expression_i.
// Output channel: out_valid_o/out_ready_i with out_symbol_o, last_of_run_o,
// end_marker_o and error_o. Each input transaction yields zero or more output
// transactions; last_of_run_o flags the final one of its run.
// '(' and operators that pop nothing produce no output.
// With idle queue and engine, an accepted item is first written into the
// two-entry command queue, whose head the stack engine turns into the output
// register, where the item's first result appears.
// Per item the stack engine emits an operand or pushes a '('; for an operator
// it pops and emits each stacked operator of equal or higher precedence, then
// pushes; for ')' it pops each operator and then the '(' (an unmatched ')' ends
// on its last pop, or only flags on an empty stack); for an end item it pops
// each stacked entry, then emits the end marker. It does a single pop per cycle when not stalled.
// A full stack drops the push and sets the sticky error flag, as does an
// unmatched ')'; the flag is reported on the end marker and then cleared.
// Reset empties the stack, the queue and the output register; no clearing
// pass is needed. When out_ready_i is low with a result held, the output
// register holds, steps that emit stall, and the queue still takes up to two items.
module infix_to_postfix_converter_unit #(
  parameter int unsigned STACK_DEPTH = itp_pkg::STACK_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] symbol_i,
  input  logic       end_of_expression_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_symbol_o,
  output logic       last_of_run_o,
  output logic       end_marker_o,
  output logic       error_o
);

  itp_pkg::cmd_t cmd;
  logic          cmd_valid, cmd_pop;

  itp_front u_front (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .symbol_i            (symbol_i),
    .end_of_expression_i (end_of_expression_i),
    .cmd_valid_o         (cmd_valid),
    .cmd_pop_i           (cmd_pop),
    .cmd_o               (cmd)
  );

  itp_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (cmd_valid),
    .cmd_pop_o     (cmd_pop),
    .cmd_i         (cmd),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_symbol_o  (out_symbol_o),
    .last_of_run_o (last_of_run_o),
    .end_marker_o  (end_marker_o),
    .error_o       (error_o)
  );

endmodule

// File: hw/rtl/itp_front.sv
`include "assert_macros.svh"

module itp_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        symbol_i,
  input  logic              end_of_expression_i,
  output logic              cmd_valid_o,
  input  logic              cmd_pop_i,
  output itp_pkg::cmd_t     cmd_o
);

  localparam int unsigned QD = itp_pkg::QUEUE_DEPTH;
  localparam int unsigned PW = (QD > 1) ? $clog2(QD) : 1;
  localparam int unsigned CW = $clog2(QD + 1);

  itp_pkg::cmd_t cls;
  itp_pkg::cmd_t q_mem_q [QD];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] q_cnt_q, q_cnt_d;
  logic          push, pop;

  // classify the incoming character
  always_comb begin
    cls.sym  = symbol_i;
    cls.code = itp_pkg::CODE_LPAREN;
    cls.kind = itp_pkg::CMD_OPERAND;
    if (end_of_expression_i) begin
      cls.kind = itp_pkg::CMD_END;
    end else begin
      unique case (symbol_i)
        itp_pkg::CHAR_LPAREN: cls.kind = itp_pkg::CMD_LPAREN;
        itp_pkg::CHAR_RPAREN: cls.kind = itp_pkg::CMD_RPAREN;
        itp_pkg::CHAR_ADD: begin
          cls.kind = itp_pkg::CMD_OPER;
          cls.code = itp_pkg::CODE_ADD;
        end
        itp_pkg::CHAR_SUB: begin
          cls.kind = itp_pkg::CMD_OPER;
          cls.code = itp_pkg::CODE_SUB;
        end
        itp_pkg::CHAR_MUL: begin
          cls.kind = itp_pkg::CMD_OPER;
          cls.code = itp_pkg::CODE_MUL;
        end
        itp_pkg::CHAR_DIV: begin
          cls.kind = itp_pkg::CMD_OPER;
          cls.code = itp_pkg::CODE_DIV;
        end
        default: cls.kind = itp_pkg::CMD_OPERAND;
      endcase
    end
  end

  assign in_ready_o  = (q_cnt_q != CW'(QD));
  assign push        = in_valid_i && in_ready_o;
  assign cmd_valid_o = (q_cnt_q != '0);
  assign pop         = cmd_valid_o && cmd_pop_i;
  assign cmd_o       = q_mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    q_cnt_d  = q_cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PW'(QD - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(QD - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (push && !pop) begin
      q_cnt_d = q_cnt_q + CW'(1);
    end else if (pop && !push) begin
      q_cnt_d = q_cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      q_cnt_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      q_cnt_q  <= q_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= cls;
    end
  end

  `ASSERT_ALWAYS(a_queue_bound, clk_i, rst_ni, q_cnt_q <= CW'(QD))
  `ASSERT_NEXT(a_queue_fill, clk_i, rst_ni, push && !pop, q_cnt_q == $past(q_cnt_q) + CW'(1))
  `ASSERT_IMPLIES(a_no_push_when_full, clk_i, rst_ni, q_cnt_q == CW'(QD), !push)

endmodule

// File: hw/rtl/itp_back.sv
`include "assert_macros.svh"

module itp_back #(
  parameter int unsigned STACK_DEPTH = itp_pkg::STACK_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  output logic          cmd_pop_o,
  input  itp_pkg::cmd_t cmd_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [7:0]    out_symbol_o,
  output logic          last_of_run_o,
  output logic          end_marker_o,
  output logic          error_o
);

  localparam int unsigned IW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  // entries below the top; the top itself lives in top_q
  logic [2:0]    stack_mem [STACK_DEPTH];
  logic [CW-1:0] cnt_q, cnt_d, cnt_m1, rd_cnt;
  logic [2:0]    top_q, top_d, below_q;
  logic          err_q, err_d;
  logic [IW-1:0] waddr, raddr;
  logic          wr_en;

  logic          out_valid_q;
  logic [7:0]    out_sym_q;
  logic          out_last_q, out_end_q, out_err_q;

  logic          can_emit, has, one, full;
  logic          emit, e_last, e_end, e_err;
  logic [7:0]    e_sym;
  logic          do_push, do_pop, err_set, err_clr;
  logic [2:0]    push_code;
  logic [1:0]    p_in;

  assign can_emit = !out_valid_q || out_ready_i;
  assign has      = (cnt_q != '0);
  assign one      = (cnt_q == CW'(1));
  assign full     = (cnt_q == CW'(STACK_DEPTH));
  assign p_in     = itp_pkg::prec_of(cmd_i.code);

  always_comb begin
    cmd_pop_o = 1'b0;
    emit      = 1'b0;
    e_sym     = '0;
    e_last    = 1'b0;
    e_end     = 1'b0;
    e_err     = 1'b0;
    do_push   = 1'b0;
    do_pop    = 1'b0;
    err_set   = 1'b0;
    err_clr   = 1'b0;
    push_code = cmd_i.code;
    if (cmd_valid_i) begin
      unique case (cmd_i.kind)
        itp_pkg::CMD_OPERAND: begin
          if (can_emit) begin
            emit      = 1'b1;
            e_sym     = cmd_i.sym;
            e_last    = 1'b1;
            cmd_pop_o = 1'b1;
          end
        end
        itp_pkg::CMD_LPAREN: begin
          do_push   = 1'b1;
          push_code = itp_pkg::CODE_LPAREN;
          cmd_pop_o = 1'b1;
        end
        itp_pkg::CMD_RPAREN: begin
          if (!has) begin
            err_set   = 1'b1;
            cmd_pop_o = 1'b1;
          end else if (top_q == itp_pkg::CODE_LPAREN) begin
            do_pop    = 1'b1;
            cmd_pop_o = 1'b1;
          end else if (can_emit) begin
            emit   = 1'b1;
            e_sym  = itp_pkg::code_char(top_q);
            e_last = one || (below_q == itp_pkg::CODE_LPAREN);
            do_pop = 1'b1;
            if (one) begin
              // ran out of stack without meeting '('
              err_set   = 1'b1;
              cmd_pop_o = 1'b1;
            end
          end
        end
        itp_pkg::CMD_OPER: begin
          if (has && (top_q != itp_pkg::CODE_LPAREN) &&
              (itp_pkg::prec_of(top_q) >= p_in)) begin
            if (can_emit) begin
              emit   = 1'b1;
              e_sym  = itp_pkg::code_char(top_q);
              e_last = one || (below_q == itp_pkg::CODE_LPAREN) ||
                       (itp_pkg::prec_of(below_q) < p_in);
              do_pop = 1'b1;
            end
          end else begin
            do_push   = 1'b1;
            cmd_pop_o = 1'b1;
          end
        end
        itp_pkg::CMD_END: begin
          if (can_emit) begin
            emit = 1'b1;
            if (has) begin
              e_sym  = itp_pkg::code_char(top_q);
              do_pop = 1'b1;
            end else begin
              e_end     = 1'b1;
              e_err     = err_q;
              e_last    = 1'b1;
              err_clr   = 1'b1;
              cmd_pop_o = 1'b1;
            end
          end
        end
        default: cmd_pop_o = 1'b1;
      endcase
    end
  end

  // stack update
  assign cnt_m1 = cnt_q - CW'(1);
  assign waddr  = cnt_m1[IW-1:0];
  assign wr_en  = do_push && !full && has;

  always_comb begin
    cnt_d = cnt_q;
    top_d = top_q;
    err_d = err_q;
    if (do_push) begin
      if (full) begin
        err_d = 1'b1;
      end else begin
        cnt_d = cnt_q + CW'(1);
        top_d = push_code;
      end
    end else if (do_pop) begin
      cnt_d = cnt_m1;
      top_d = below_q;
    end
    if (err_set) begin
      err_d = 1'b1;
    end else if (err_clr) begin
      err_d = 1'b0;
    end
  end

  // keep below_q tracking the entry under the next top
  assign rd_cnt = cnt_d - CW'(2);
  assign raddr  = rd_cnt[IW-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      stack_mem[waddr] <= top_q;
    end
    if (wr_en && (waddr == raddr)) begin
      below_q <= top_q;
    end else begin
      below_q <= stack_mem[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      err_q <= err_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    top_q <= top_d;
    if (emit) begin
      out_sym_q  <= e_sym;
      out_last_q <= e_last;
      out_end_q  <= e_end;
      out_err_q  <= e_err;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_symbol_o  = out_sym_q;
  assign last_of_run_o = out_last_q;
  assign end_marker_o  = out_end_q;
  assign error_o       = out_err_q;

  `ASSERT_ALWAYS(a_stack_bound, clk_i, rst_ni, cnt_q <= CW'(STACK_DEPTH))
  `ASSERT_IMPLIES(a_err_only_on_end, clk_i, rst_ni, out_valid_q && !out_end_q, !out_err_q)
  `ASSERT_NEXT(a_end_clears_err, clk_i, rst_ni, emit && e_end, !err_q && (cnt_q == '0))
  `ASSERT_IMPLIES(a_no_push_and_pop, clk_i, rst_ni, do_push, !do_pop)

endmodule
